>>> src/b2d_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; every other file imports this package.
`default_nettype none

package b2d_pkg;

   localparam int NUM_W      = 32;            // binary input width
   localparam int DIGITS     = 10;            // decimal digits of a 32-bit value
   localparam int BCD_W      = DIGITS * 4;
   localparam int CHAR_W     = 8;
   localparam int CNT_W      = 4;             // holds 0..10
   localparam int STEP_W     = $clog2(NUM_W);
   localparam int IDX_W      = $clog2(DIGITS);

   localparam logic [STEP_W-1:0] LAST_STEP       = STEP_W'(NUM_W - 1);
   localparam logic [CHAR_W-1:0] ASCII_ZERO      = 8'h30;
   localparam logic [CNT_W-1:0]  MAX_DIGITS_RST  = CNT_W'(DIGITS);
   localparam logic [3:0]        DABBLE_LIMIT    = 4'd5;
   localparam logic [3:0]        DABBLE_ADD      = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_COUNT,
      ST_EMIT
   } b2d_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture a new number, clear the BCD register
      logic step;     // one shift-add-3 step
      logic count;    // find digit count, overflow flag and first index
      logic emit;     // load the next result beat into the output register
   } b2d_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;   // output register empty or being drained this cycle
      logic last_beat;  // the beat about to go out ends this number
   } b2d_status_type;

endpackage

`default_nettype wire

>>> src/b2d_ifs.sv
// Handshake channel interfaces: request, response and register write.
// Depends on b2d_pkg for field widths.
`default_nettype none

interface b2d_req_if;
   import b2d_pkg::*;
   logic              valid;
   logic              ready;
   logic [NUM_W-1:0]  number;
   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface b2d_rsp_if;
   import b2d_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              is_last;
   logic              too_long;
   logic [CNT_W-1:0]  digit_count;
   modport source (output valid, output digit_char, output is_last, output too_long,
                   output digit_count, input ready);
   modport sink   (input valid, input digit_char, input is_last, input too_long,
                   input digit_count, output ready);
endinterface

interface b2d_csr_if;
   import b2d_pkg::*;
   logic              valid;
   logic              ready;
   logic [CNT_W-1:0]  max_digits;
   modport source (output valid, output max_digits, input ready);
   modport sink   (input valid, input max_digits, output ready);
endinterface

`default_nettype wire

>>> src/b2d_ctrl.sv
// Sequencer for the converter: idle, 32 double-dabble steps, count, emit.
// Depends on b2d_pkg for the state, command and status types.
`default_nettype none

module b2d_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  b2d_pkg::b2d_status_type status,
   output b2d_pkg::b2d_cmd_type    cmd
);
   import b2d_pkg::*;

   b2d_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff,  step_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_CONVERT;
         ST_CONVERT: if (step_ff == LAST_STEP) state_in = ST_COUNT;
         ST_COUNT:   state_in = ST_EMIT;
         ST_EMIT:    if (status.out_free && status.last_beat) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      step_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
         end
         ST_COUNT: cmd.count = 1'b1;
         ST_EMIT:  cmd.emit  = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

>>> src/b2d_dpath.sv
// Datapath: double-dabble shift register, digit count, limit register
// and the result output register. Depends on b2d_pkg.
`default_nettype none

module b2d_dpath (
   input  wire                          clock,
   input  wire                          reset,
   input  b2d_pkg::b2d_cmd_type         cmd,
   output b2d_pkg::b2d_status_type      status,
   input  wire [b2d_pkg::NUM_W-1:0]     req_number,
   input  wire                          csr_valid,
   input  wire [b2d_pkg::CNT_W-1:0]     csr_max_digits,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [b2d_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                         rsp_is_last,
   output logic                         rsp_too_long,
   output logic [b2d_pkg::CNT_W-1:0]    rsp_digit_count
);
   import b2d_pkg::*;

   logic [NUM_W-1:0]  bin_ff,   bin_in;
   logic [BCD_W-1:0]  bcd_ff,   bcd_in;
   logic [BCD_W-1:0]  bcd_adj;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [IDX_W-1:0]  idx_ff,   idx_in;
   logic              ovf_ff,   ovf_in;
   logic [CNT_W-1:0]  maxd_ff,  maxd_in;
   logic              vld_ff,   vld_in;
   logic [CHAR_W-1:0] char_ff,  char_in;
   logic              last_ff,  last_in;
   logic              tlong_ff, tlong_in;
   logic [CNT_W-1:0]  dcnt_ff,  dcnt_in;
   logic [CNT_W-1:0]  found;
   logic [3:0]        nib;

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         bcd_adj[k*4 +: 4] = (bcd_ff[k*4 +: 4] >= DABBLE_LIMIT)
                           ? bcd_ff[k*4 +: 4] + DABBLE_ADD : bcd_ff[k*4 +: 4];
      end
   end

   // highest nonzero digit; zero still has one digit
   always_comb begin
      found = CNT_W'(1);
      for (int k = 1; k < DIGITS; k++) begin
         if (bcd_ff[k*4 +: 4] != 4'd0) found = CNT_W'(k + 1);
      end
   end

   assign nib = bcd_ff[{idx_ff, 2'b00} +: 4];

   assign status.out_free  = !vld_ff || rsp_ready;
   assign status.last_beat = ovf_ff || (idx_ff == '0);

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      ovf_in   = ovf_ff;
      maxd_in  = csr_valid ? csr_max_digits : maxd_ff;
      vld_in   = rsp_ready ? 1'b0 : vld_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      tlong_in = tlong_ff;
      dcnt_in  = dcnt_ff;
      if (cmd.load) begin
         bin_in = req_number;
         bcd_in = '0;
      end
      if (cmd.step) begin
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[NUM_W-1]};
         bin_in = {bin_ff[NUM_W-2:0], 1'b0};
      end
      if (cmd.count) begin
         cnt_in = found;
         ovf_in = found > maxd_ff;
         idx_in = IDX_W'(found - 1'b1);
      end
      if (cmd.emit) begin
         vld_in = 1'b1;
         if (ovf_ff) begin
            char_in  = '0;
            last_in  = 1'b1;
            tlong_in = 1'b1;
            dcnt_in  = '0;
         end else begin
            char_in  = ASCII_ZERO + CHAR_W'(nib);
            last_in  = (idx_ff == '0);
            tlong_in = 1'b0;
            dcnt_in  = cnt_ff;
            idx_in   = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxd_ff <= MAX_DIGITS_RST;
         vld_ff  <= 1'b0;
      end else begin
         maxd_ff <= maxd_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      ovf_ff   <= ovf_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      tlong_ff <= tlong_in;
      dcnt_ff  <= dcnt_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_digit_char  = char_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_too_long    = tlong_ff;
   assign rsp_digit_count = dcnt_ff;

endmodule

`default_nettype wire

>>> src/binary_to_decimal_ascii.sv
// Top level of the unsigned 32-bit binary to decimal ASCII converter.
// Depends on b2d_pkg, the channel interfaces, b2d_ctrl and b2d_dpath.
//
//  channel   dir  per beat
//  -------   ---  -------------------------------------------------------
//  req_bus   in   number[31:0]
//  rsp_bus   out  digit_char[7:0], is_last, too_long, digit_count[3:0]
//  csr_bus   in   max_digits[3:0] (always ready, reset value 10)
//
// A number is accepted, then runs 32 double-dabble steps through the single
// shift-add-3 stage, then its digit count is found, and its n result beats
// leave the output register at one beat per cycle while rsp_bus is ready.
// A stalled rsp_bus holds the beat and pauses the emit sequencer; req_bus
// is ready again once the last beat sits in the output register.
// Synchronous active-high reset returns to idle and sets max_digits to 10.
`default_nettype none

module binary_to_decimal_ascii (
   input  wire        clock,
   input  wire        reset,
   b2d_req_if.sink    req_bus,
   b2d_rsp_if.source  rsp_bus,
   b2d_csr_if.sink    csr_bus
);
   import b2d_pkg::*;

   b2d_cmd_type    cmd;
   b2d_status_type status;

   // register writes are always accepted and go straight into the limit register
   assign csr_bus.ready = 1'b1;

   b2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   b2d_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_number      (req_bus.number),
      .csr_valid       (csr_bus.valid),
      .csr_max_digits  (csr_bus.max_digits),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_digit_char  (rsp_bus.digit_char),
      .rsp_is_last     (rsp_bus.is_last),
      .rsp_too_long    (rsp_bus.too_long),
      .rsp_digit_count (rsp_bus.digit_count)
   );

endmodule

`default_nettype wire
